### sv/i2r_pkg.sv
package i2r_pkg;

    // Input range that converts to a numeral
    localparam logic [11:0] VALUE_MIN = 12'd1;
    localparam logic [11:0] VALUE_MAX = 12'd3999;

    // ASCII codes of the numeral letters
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_NONE = 8'h00;

    // Greedy token table: M CM D CD C XC L XL X IX V IV I
    localparam int TOK_NUM = 13;
    localparam int TOK_IDX_W = 4;
    localparam logic [TOK_IDX_W-1:0] TOK_LAST = TOK_IDX_W'(TOK_NUM - 1);

    typedef struct packed {
        logic [11:0] weight;
        logic [7:0]  first;
        logic [7:0]  second;
        logic        pair;
    } tok_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture the input word
        logic step;         // emit first letter of the next token, subtract its weight
        logic emit_second;  // emit the held second letter of a pair token
        logic emit_error;   // emit the out-of-range word
    } i2r_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic value_ok;       // input word lies in 1..3999
        logic out_free;       // output register can take a word this cycle
        logic two_char;       // selected token has two letters
        logic rem_zero_after; // remainder is zero once the selected token is taken
        logic rem_zero;       // stored remainder is zero
    } i2r_stat_t;

    function automatic tok_t tok_info(input logic [TOK_IDX_W-1:0] idx);
        tok_t t;
        case (idx)
            4'd0:    t = '{weight: 12'd1000, first: CH_M, second: CH_NONE, pair: 1'b0};
            4'd1:    t = '{weight: 12'd900,  first: CH_C, second: CH_M,    pair: 1'b1};
            4'd2:    t = '{weight: 12'd500,  first: CH_D, second: CH_NONE, pair: 1'b0};
            4'd3:    t = '{weight: 12'd400,  first: CH_C, second: CH_D,    pair: 1'b1};
            4'd4:    t = '{weight: 12'd100,  first: CH_C, second: CH_NONE, pair: 1'b0};
            4'd5:    t = '{weight: 12'd90,   first: CH_X, second: CH_C,    pair: 1'b1};
            4'd6:    t = '{weight: 12'd50,   first: CH_L, second: CH_NONE, pair: 1'b0};
            4'd7:    t = '{weight: 12'd40,   first: CH_X, second: CH_L,    pair: 1'b1};
            4'd8:    t = '{weight: 12'd10,   first: CH_X, second: CH_NONE, pair: 1'b0};
            4'd9:    t = '{weight: 12'd9,    first: CH_I, second: CH_X,    pair: 1'b1};
            4'd10:   t = '{weight: 12'd5,    first: CH_V, second: CH_NONE, pair: 1'b0};
            4'd11:   t = '{weight: 12'd4,    first: CH_I, second: CH_V,    pair: 1'b1};
            default: t = '{weight: 12'd1,    first: CH_I, second: CH_NONE, pair: 1'b0};
        endcase
        return t;
    endfunction

endpackage

### sv/i2r_ctrl.sv
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  i2r_stat_t stat,
    output i2r_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERR,
        S_RUN,
        S_SECOND
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.value_ok ? S_RUN : S_ERR;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_error = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.two_char)
                        state_next = S_SECOND;
                    else if (stat.rem_zero_after)
                        state_next = S_IDLE;
                end
            end
            S_SECOND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_second = 1'b1;
                    state_next      = stat.rem_zero ? S_IDLE : S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // New words only while no numeral is in progress
    assign item_stall = (state_reg != S_IDLE);

endmodule

### sv/i2r_datapath.sv
module i2r_datapath
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] value,
    input  i2r_cmd_t    cmd,
    output i2r_stat_t   stat,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        error
);

    logic [11:0]          rem_reg;
    logic [11:0]          rem_next;
    logic [7:0]           second_reg;
    logic [7:0]           second_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           symbol_reg;
    logic [7:0]           symbol_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 error_reg;
    logic                 error_next;
    logic [TOK_IDX_W-1:0] sel;
    tok_t                 tok;
    logic [11:0]          rem_sub;
    logic                 emit;

    // Largest token not above the remainder (weights descend with index)
    always_comb
    begin
        tok_t cand;
        sel = TOK_LAST;
        for (int i = TOK_NUM - 1; i >= 0; i--)
        begin
            cand = tok_info(TOK_IDX_W'(i));
            if (rem_reg >= cand.weight)
                sel = TOK_IDX_W'(i);
        end
    end

    assign tok     = tok_info(sel);
    assign rem_sub = rem_reg - tok.weight;
    assign emit    = cmd.step | cmd.emit_second | cmd.emit_error;

    // Status back to the controller
    assign stat.value_ok       = (value >= VALUE_MIN) && (value <= VALUE_MAX);
    assign stat.out_free       = !out_valid_reg || !result_stall;
    assign stat.two_char       = tok.pair;
    assign stat.rem_zero_after = (rem_sub == 12'd0);
    assign stat.rem_zero       = (rem_reg == 12'd0);

    // Remainder and held second letter
    always_comb
    begin
        rem_next    = rem_reg;
        second_next = second_reg;
        if (cmd.load)
            rem_next = value;
        else if (cmd.step)
        begin
            rem_next    = rem_sub;
            second_next = tok.second;
        end
    end

    // Output word
    always_comb
    begin
        symbol_next = symbol_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        if (cmd.step)
        begin
            symbol_next = tok.first;
            last_next   = !tok.pair && (rem_sub == 12'd0);
            error_next  = 1'b0;
        end
        else if (cmd.emit_second)
        begin
            symbol_next = second_reg;
            last_next   = (rem_reg == 12'd0);
            error_next  = 1'b0;
        end
        else if (cmd.emit_error)
        begin
            symbol_next = CH_NONE;
            last_next   = 1'b1;
            error_next  = 1'b1;
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        second_reg <= second_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    assign result_valid = out_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign error        = error_reg;

endmodule

### sv/integer_to_roman_numeral_unit.sv
// A word is loaded into the remainder register; letters go to the output register.
// A new word waits until the previous one's last letter or error word is written;
// one letter per cycle from the greedy token unit while the output is not stalled.
// Output is registered; a held result stalls letter and error-word generation only.
// Reset: rst_n is asynchronous, active low; controller idles and the output is empty.
module integer_to_roman_numeral_unit
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [11:0] value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  symbol,
    output logic        last,
    output logic        error
);

    i2r_cmd_t  cmd;
    i2r_stat_t stat;

    i2r_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    i2r_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .symbol       (symbol),
        .last         (last),
        .error        (error)
    );

endmodule
